[hdl/assert_macros.svh]
// Assertion macros shared by the matcher's RTL modules.
// No dependencies; included by each module that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/fslm_pkg.sv]
// Package of the fixed-string line matcher: field widths, command and register codes,
// controller states, controller/datapath command and status structs, byte helpers.
// No dependencies.
package fslm_pkg;

    localparam int CMD_W      = 2;
    localparam int SLOT_W     = 3;
    localparam int POS_W      = 6;
    localparam int PLEN_W     = 7;
    localparam int BYTE_W     = 8;
    localparam int OFS_W      = 11;
    localparam int COUNT_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_PAT_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PAT_LEN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LINE_BYTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_MATCH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MATCH    = 3'd3;

    localparam logic [BYTE_W-1:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_LO = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_HI = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_LO = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_HI = 8'h7A;
    localparam logic [BYTE_W-1:0] UNDERSCORE    = 8'h5F;
    localparam logic [BYTE_W-1:0] CASE_OFFSET   = 8'h20;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_SETUP,
        S_POS,
        S_RD,
        S_CMP,
        S_WL,
        S_WLC,
        S_WR,
        S_WRC,
        S_HIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic search_init;
        logic plen_load;
        logic slot_next;
        logic j_init;
        logic j_next;
        logic k_clear;
        logic k_next;
        logic rd_cmp;
        logic rd_left;
        logic rd_right;
        logic set_hit;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic line_last;
        logic line_mode;
        logic word_mode;
        logic slot_done;
        logic plen_zero;
        logic plen_eq_len;
        logic pos_fits;
        logic k_done;
        logic byte_eq;
        logic has_left;
        logic has_right;
        logic q_is_word;
    } t_dp_status;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c,
                                                    input logic ic);
        logic [BYTE_W-1:0] r;
        r = c;
        if (ic && c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
               (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
               (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) ||
               (c == UNDERSCORE);
    endfunction

endpackage

[hdl/fslm_in_if.sv]
// Input request channel of the matcher: valid/ready plus one command item.
// Depends on fslm_pkg.
interface fslm_in_if import fslm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] pattern_slot;
    logic [POS_W-1:0]  pattern_position;
    logic [PLEN_W-1:0] pattern_length;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
    logic [OFS_W-1:0]  search_from;

    modport source(output valid, command, pattern_slot, pattern_position, pattern_length,
                   data_byte, last_byte, search_from, input ready);
    modport sink(input valid, command, pattern_slot, pattern_position, pattern_length,
                 data_byte, last_byte, search_from, output ready);
endinterface

[hdl/fslm_out_if.sv]
// Result channel of the matcher: valid/ready plus one search result.
// Depends on fslm_pkg.
interface fslm_out_if import fslm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [OFS_W-1:0] match_start;
    logic [OFS_W-1:0] match_end;
    logic             line_overflow;

    modport source(output valid, found, match_start, match_end, line_overflow, input ready);
    modport sink(input valid, found, match_start, match_end, line_overflow, output ready);
endinterface

[hdl/fslm_cfg_if.sv]
// Configuration write channel of the matcher: valid/ready, register index and data.
// Depends on fslm_pkg.
interface fslm_cfg_if import fslm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[hdl/fslm_ctrl.sv]
// Controller of the matcher: sequences the end-of-line search over slots,
// candidate positions and pattern bytes. Depends on fslm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fslm_ctrl import fslm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_accept,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_ready,
    output logic       o_out_valid
);

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd w_cmd;
    logic    r_out_valid;
    logic    w_go;

    assign w_go = i_in_accept && i_status.line_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_go) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_state = i_status.slot_done ? S_DONE : S_SETUP;
            end
            S_SETUP: begin
                if (i_status.line_mode && !i_status.plen_eq_len) begin
                    n_state = S_SLOT;
                end else if (!i_status.line_mode && i_status.plen_zero) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                n_state = i_status.pos_fits ? S_RD : S_SLOT;
            end
            S_RD: begin
                if (i_status.k_done) begin
                    n_state = (i_status.word_mode && !i_status.line_mode) ? S_WL : S_HIT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = i_status.byte_eq ? S_RD : S_POS;
            end
            S_WL: begin
                n_state = i_status.has_left ? S_WLC : S_WR;
            end
            S_WLC: begin
                n_state = i_status.q_is_word ? S_POS : S_WR;
            end
            S_WR: begin
                n_state = i_status.has_right ? S_WRC : S_HIT;
            end
            S_WRC: begin
                n_state = i_status.q_is_word ? S_POS : S_HIT;
            end
            S_HIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.search_init = w_go;
            end
            S_SLOT: begin
                w_cmd.plen_load = !i_status.slot_done;
            end
            S_SETUP: begin
                w_cmd.j_init    = 1'b1;
                w_cmd.slot_next = i_status.line_mode && !i_status.plen_eq_len;
            end
            S_POS: begin
                w_cmd.k_clear   = 1'b1;
                w_cmd.slot_next = !i_status.pos_fits;
            end
            S_RD: begin
                w_cmd.rd_cmp = !i_status.k_done;
            end
            S_CMP: begin
                w_cmd.k_next = i_status.byte_eq;
                w_cmd.j_next = !i_status.byte_eq;
            end
            S_WL: begin
                w_cmd.rd_left = i_status.has_left;
            end
            S_WLC: begin
                w_cmd.j_next = i_status.q_is_word;
            end
            S_WR: begin
                w_cmd.rd_right = i_status.has_right;
            end
            S_WRC: begin
                w_cmd.j_next = i_status.q_is_word;
            end
            S_HIT: begin
                w_cmd.set_hit = 1'b1;
            end
            S_DONE: begin
                w_cmd.out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `FSLM_ASSERT_NOW(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !i_in_accept, "request accepted during search")
    `FSLM_ASSERT_NEXT(a_go_starts, i_clk, i_rst_n, w_go, r_state == S_SLOT, "line end did not start search")
    `FSLM_ASSERT_NOW(a_result_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE, "result offered outside search end")

endmodule

[hdl/fslm_dpath.sv]
// Datapath of the matcher: configuration registers, pattern and line memories,
// search counters, byte compare and result registers. Depends on fslm_pkg, assert_macros.svh.
`include "assert_macros.svh"

module fslm_dpath import fslm_pkg::*; #(
    parameter int MAX_PATTERNS    = 8,
    parameter int MAX_PATTERN_LEN = 64,
    parameter int MAX_LINE        = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_in_accept,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [SLOT_W-1:0]     i_pattern_slot,
    input  logic [POS_W-1:0]      i_pattern_position,
    input  logic [PLEN_W-1:0]     i_pattern_length,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_last_byte,
    input  logic [OFS_W-1:0]      i_search_from,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_found,
    output logic [OFS_W-1:0]      o_match_start,
    output logic [OFS_W-1:0]      o_match_end,
    output logic                  o_line_overflow
);

    localparam int SIW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int SCW    = $clog2(MAX_PATTERNS + 1);
    localparam int KW     = $clog2(MAX_PATTERN_LEN + 1);
    localparam int PDEPTH = MAX_PATTERNS * MAX_PATTERN_LEN;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int LAW    = $clog2(MAX_LINE);
    localparam int LLW    = $clog2(MAX_LINE + 1);
    localparam int JW     = $clog2(((MAX_LINE + 1) > (1 << OFS_W)) ? (MAX_LINE + 1)
                                                                  : (1 << OFS_W));

    logic [COUNT_W-1:0] r_count;
    logic               r_ignore_case;
    logic               r_word_match;
    logic               r_line_match;

    logic [KW-1:0]      r_len_tab [MAX_PATTERNS];
    logic [BYTE_W-1:0]  r_pat_mem [PDEPTH];
    logic [BYTE_W-1:0]  r_line_mem [MAX_LINE];
    logic [BYTE_W-1:0]  r_pat_q;
    logic [BYTE_W-1:0]  r_line_q;

    logic [LLW-1:0]     r_line_len;
    logic               r_overflow;
    logic [OFS_W-1:0]   r_from;
    logic [SCW-1:0]     r_slot;
    logic [KW-1:0]      r_plen;
    logic [KW-1:0]      r_k;
    logic [JW-1:0]      r_j;
    logic               r_found;
    logic [JW-1:0]      r_hit_start;
    logic [JW:0]        r_hit_end;

    logic               r_o_found;
    logic [OFS_W-1:0]   r_o_start;
    logic [OFS_W-1:0]   r_o_end;
    logic               r_o_overflow;

    logic               w_slot_ok;
    logic               w_pos_ok;
    logic               w_pat_wr;
    logic               w_len_wr;
    logic               w_line_byte;
    logic               w_line_room;
    logic               w_line_wr;
    logic [SIW-1:0]     w_wslot;
    logic [SIW-1:0]     w_rslot;
    logic [PAW-1:0]     w_pat_waddr;
    logic [PAW-1:0]     w_pat_raddr;
    logic [JW:0]        w_j_end;
    logic [JW:0]        w_len_ext;
    logic [JW:0]        w_line_raddr_full;
    logic [LAW-1:0]     w_line_raddr;
    logic               w_line_rd;

    assign w_slot_ok   = 32'(i_pattern_slot) < MAX_PATTERNS;
    assign w_pos_ok    = 32'(i_pattern_position) < MAX_PATTERN_LEN;
    assign w_pat_wr    = i_in_accept && (i_command == CMD_PAT_BYTE) && w_slot_ok && w_pos_ok;
    assign w_len_wr    = i_in_accept && (i_command == CMD_PAT_LEN) && w_slot_ok;
    assign w_line_byte = i_in_accept && (i_command == CMD_LINE_BYTE);
    assign w_line_room = 32'(r_line_len) < MAX_LINE;
    assign w_line_wr   = w_line_byte && w_line_room;

    assign w_wslot     = SIW'(i_pattern_slot);
    assign w_rslot     = r_slot[SIW-1:0];
    assign w_pat_waddr = PAW'(32'(w_wslot) * MAX_PATTERN_LEN + 32'(i_pattern_position));
    assign w_pat_raddr = PAW'(32'(w_rslot) * MAX_PATTERN_LEN + 32'(r_k));

    assign w_j_end   = {1'b0, r_j} + (JW + 1)'(r_plen);
    assign w_len_ext = (JW + 1)'(r_line_len);

    always_comb begin
        priority if (i_cmd.rd_left) begin
            w_line_raddr_full = {1'b0, r_j} - (JW + 1)'(1);
        end else if (i_cmd.rd_right) begin
            w_line_raddr_full = w_j_end;
        end else begin
            w_line_raddr_full = {1'b0, r_j} + (JW + 1)'(r_k);
        end
    end

    assign w_line_raddr = w_line_raddr_full[LAW-1:0];
    assign w_line_rd    = i_cmd.rd_cmp || i_cmd.rd_left || i_cmd.rd_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_ignore_case <= 1'b0;
            r_word_match  <= 1'b0;
            r_line_match  <= 1'b0;
            r_line_len    <= '0;
            r_overflow    <= 1'b0;
            r_slot        <= '0;
            r_plen        <= '0;
            r_k           <= '0;
            r_j           <= '0;
            r_found       <= 1'b0;
            for (int i = 0; i < MAX_PATTERNS; i++) begin
                r_len_tab[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PATTERN_COUNT: r_count       <= i_cfg_data[COUNT_W-1:0];
                    CFG_IGNORE_CASE:   r_ignore_case <= i_cfg_data[0];
                    CFG_WORD_MATCH:    r_word_match  <= i_cfg_data[0];
                    CFG_LINE_MATCH:    r_line_match  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (w_len_wr) begin
                if (32'(i_pattern_length) > MAX_PATTERN_LEN) begin
                    r_len_tab[w_wslot] <= KW'(MAX_PATTERN_LEN);
                end else begin
                    r_len_tab[w_wslot] <= KW'(i_pattern_length);
                end
            end
            priority if (i_cmd.out_load) begin
                r_line_len <= '0;
                r_overflow <= 1'b0;
            end else if (w_line_wr) begin
                r_line_len <= r_line_len + LLW'(1);
            end else if (w_line_byte) begin
                r_overflow <= 1'b1;
            end
            if (i_cmd.search_init) begin
                r_slot  <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.slot_next) begin
                r_slot <= r_slot + SCW'(1);
            end
            if (i_cmd.plen_load) begin
                r_plen <= r_len_tab[w_rslot];
            end
            if (i_cmd.k_clear) begin
                r_k <= '0;
            end else if (i_cmd.k_next) begin
                r_k <= r_k + KW'(1);
            end
            if (i_cmd.j_init) begin
                r_j <= r_line_match ? '0 : JW'(r_from);
            end else if (i_cmd.j_next) begin
                r_j <= r_j + JW'(1);
            end
            if (i_cmd.set_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.search_init) begin
            r_from <= i_search_from;
        end
        if (i_cmd.set_hit) begin
            r_hit_start <= r_j;
            r_hit_end   <= w_j_end;
        end
        if (i_cmd.out_load) begin
            r_o_found    <= r_found;
            r_o_start    <= r_found ? r_hit_start[OFS_W-1:0] : '0;
            r_o_end      <= r_found ? r_hit_end[OFS_W-1:0] : '0;
            r_o_overflow <= r_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pat_wr) begin
            r_pat_mem[w_pat_waddr] <= i_data_byte;
        end
        if (i_cmd.rd_cmp) begin
            r_pat_q <= r_pat_mem[w_pat_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_line_wr) begin
            r_line_mem[r_line_len[LAW-1:0]] <= i_data_byte;
        end
        if (w_line_rd) begin
            r_line_q <= r_line_mem[w_line_raddr];
        end
    end

    always_comb begin
        o_status.line_last   = (i_command == CMD_LINE_BYTE) && i_last_byte;
        o_status.line_mode   = r_line_match;
        o_status.word_mode   = r_word_match;
        o_status.slot_done   = (32'(r_slot) >= 32'(r_count)) || (32'(r_slot) >= MAX_PATTERNS);
        o_status.plen_zero   = (r_plen == '0);
        o_status.plen_eq_len = ((JW + 1)'(r_plen) == w_len_ext);
        o_status.pos_fits    = (w_j_end <= w_len_ext);
        o_status.k_done      = (r_k == r_plen);
        o_status.byte_eq     = fold_case(r_line_q, r_ignore_case) ==
                               fold_case(r_pat_q, r_ignore_case);
        o_status.has_left    = (r_j != '0);
        o_status.has_right   = (w_j_end < w_len_ext);
        o_status.q_is_word   = is_word_char(r_line_q);
    end

    assign o_found         = r_o_found;
    assign o_match_start   = r_o_start;
    assign o_match_end     = r_o_end;
    assign o_line_overflow = r_o_overflow;

    `FSLM_ASSERT_NOW(a_k_in_pattern, i_clk, i_rst_n, i_cmd.k_next, r_k < r_plen, "byte index ran past pattern length")
    `FSLM_ASSERT_NOW(a_hit_ordered, i_clk, i_rst_n, r_found, r_hit_end >= {1'b0, r_hit_start}, "match end before match start")

endmodule

[hdl/fixed_string_line_matcher.sv]
// Pattern and line-byte requests are taken one per cycle while idle; a result follows only a last
// line byte. End-of-line search: for each tried slot and each candidate position, the pattern bytes
// are compared one by one through the line memory's registered read. In word mode, word-boundary
// checks follow; then the result is loaded. Ready stays low during the search.
// Synchronous active-low reset clears configuration, pattern lengths, line state and valids;
// pattern and line memories are not cleared.
module fixed_string_line_matcher import fslm_pkg::*; #(
    parameter int MAX_PATTERNS    = 8,
    parameter int MAX_PATTERN_LEN = 64,
    parameter int MAX_LINE        = 1024
) (
    input logic            i_clk,
    input logic            i_rst_n,
    fslm_in_if.sink        i_in,
    fslm_out_if.source     o_out,
    fslm_cfg_if.sink       i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_in_accept;
    logic       w_cfg_we;

    assign i_in.ready  = w_in_ready;
    assign w_in_accept = i_in.valid && w_in_ready;
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    fslm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (w_in_accept),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_in_ready  (w_in_ready),
        .o_out_valid (o_out.valid)
    );

    fslm_dpath #(
        .MAX_PATTERNS    (MAX_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .MAX_LINE        (MAX_LINE)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_in_accept        (w_in_accept),
        .i_command          (i_in.command),
        .i_pattern_slot     (i_in.pattern_slot),
        .i_pattern_position (i_in.pattern_position),
        .i_pattern_length   (i_in.pattern_length),
        .i_data_byte        (i_in.data_byte),
        .i_last_byte        (i_in.last_byte),
        .i_search_from      (i_in.search_from),
        .i_cfg_we           (w_cfg_we),
        .i_cfg_index        (i_cfg.index),
        .i_cfg_data         (i_cfg.data),
        .o_found            (o_out.found),
        .o_match_start      (o_out.match_start),
        .o_match_end        (o_out.match_end),
        .o_line_overflow    (o_out.line_overflow)
    );

endmodule

[dv/tb_fixed_string_line_matcher.sv]
// Self-checking testbench of the fixed-string line matcher: directed and random requests
// with random stalls on both channels, each result compared with a built-in predictor.
// Depends on fslm_pkg, the three channel interfaces and fixed_string_line_matcher.
module tb_fixed_string_line_matcher;
    import fslm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = 8;
    localparam int SLOT_BYTES   = 64;
    localparam int LINE_CAP     = 1024;
    localparam int QUIET_CYCLES = 16;
    localparam int RANDOM_ITEMS = 600;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CMD_W-1:0]     CMD_UNUSED       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_LINE_MATCH + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  position;
        logic [PLEN_W-1:0] length;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [OFS_W-1:0]  from;
    } t_request;

    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] match_start;
        logic [OFS_W-1:0] match_end;
        logic             line_overflow;
    } t_match;

    typedef logic [BYTE_W-1:0] t_bytes[$];

    logic i_clk;
    logic i_rst_n;

    fslm_in_if  in_if();
    fslm_out_if out_if();
    fslm_cfg_if cfg_if();

    fixed_string_line_matcher #(
        .MAX_PATTERNS   (NUM_SLOTS),
        .MAX_PATTERN_LEN(SLOT_BYTES),
        .MAX_LINE       (LINE_CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    logic [BYTE_W-1:0] pat_mem[NUM_SLOTS][SLOT_BYTES];
    bit                pat_written[NUM_SLOTS][SLOT_BYTES];
    int                pat_len[NUM_SLOTS];
    logic [BYTE_W-1:0] line_buf[LINE_CAP];
    int                line_len;
    bit                line_dropped;
    int                cfg_count;
    bit                cfg_fold;
    bit                cfg_word;
    bit                cfg_whole;

    t_match expected_q[$];
    int     errors;
    int     results_seen;
    int     requests_sent;
    int     cfg_writes;
    int     overflow_lines;
    int     stall_left;
    bit     idle_on;

    always #5 i_clk = ~i_clk;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
        if (cfg_fold && c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic bit word_byte(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) ||
               (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) ||
               (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) || c == UNDERSCORE;
    endfunction

    function automatic bit pattern_at(input int slot, input int at, input int plen);
        for (int k = 0; k < plen; k++) begin
            if (fold_byte(line_buf[at + k]) != fold_byte(pat_mem[slot][k])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_match search_line(input int from);
        t_match r;
        int     cnt;
        int     plen;
        bit     bordered;
        r = '0;
        r.line_overflow = line_dropped;
        cnt = (cfg_count > NUM_SLOTS) ? NUM_SLOTS : cfg_count;
        for (int s = 0; s < cnt; s++) begin
            plen = pat_len[s];
            if (cfg_whole) begin
                if (plen == line_len && pattern_at(s, 0, plen)) begin
                    r.found = 1'b1;
                    r.match_end = OFS_W'(line_len);
                    return r;
                end
            end else if (plen == 0) begin
                r.found = 1'b1;
                r.match_start = OFS_W'(from);
                r.match_end = OFS_W'(from);
                return r;
            end else begin
                for (int j = from; j + plen <= line_len; j++) begin
                    if (pattern_at(s, j, plen)) begin
                        bordered = cfg_word &&
                            ((j > 0 && word_byte(line_buf[j - 1])) ||
                             (j + plen < line_len && word_byte(line_buf[j + plen])));
                        if (!bordered) begin
                            r.found = 1'b1;
                            r.match_start = OFS_W'(j);
                            r.match_end = OFS_W'(j + plen);
                            return r;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void apply_request(input t_request r);
        case (r.command)
            CMD_PAT_BYTE: begin
                pat_mem[r.slot][r.position] = r.data;
                pat_written[r.slot][r.position] = 1'b1;
            end
            CMD_PAT_LEN: begin
                pat_len[r.slot] = (r.length > SLOT_BYTES) ? SLOT_BYTES : int'(r.length);
            end
            CMD_LINE_BYTE: begin
                if (line_len < LINE_CAP) begin
                    line_buf[line_len] = r.data;
                    line_len++;
                end else begin
                    line_dropped = 1'b1;
                end
                if (r.last) begin
                    expected_q.push_back(search_line(int'(r.from)));
                    if (line_dropped) begin
                        overflow_lines++;
                    end
                    line_len = 0;
                    line_dropped = 1'b0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PATTERN_COUNT: cfg_count = int'(value);
            CFG_IGNORE_CASE:   cfg_fold = value[0];
            CFG_WORD_MATCH:    cfg_word = value[0];
            CFG_LINE_MATCH:    cfg_whole = value[0];
            default: begin
            end
        endcase
    endfunction

    function automatic int written_prefix(input int slot);
        int n;
        n = 0;
        while (n < SLOT_BYTES && pat_written[slot][n]) begin
            n++;
        end
        return n;
    endfunction

    function automatic t_request filler(input logic [CMD_W-1:0] cmd);
        t_request r;
        r.command = cmd;
        r.slot = SLOT_W'($urandom);
        r.position = POS_W'($urandom);
        r.length = PLEN_W'($urandom);
        r.data = BYTE_W'($urandom);
        r.last = 1'($urandom);
        r.from = OFS_W'($urandom);
        return r;
    endfunction

    function automatic t_bytes text_bytes(input string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic t_bytes random_chars(input int n);
        string  pool;
        t_bytes q;
        pool = "aAbBzZ09_ -.";
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                q.push_back(BYTE_W'($urandom));
            end else begin
                q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            end
        end
        return q;
    endfunction

    function automatic t_bytes stored_variant(input int slot);
        t_bytes            q;
        logic [BYTE_W-1:0] c;
        for (int k = 0; k < pat_len[slot]; k++) begin
            c = pat_mem[slot][k];
            if ((c | CASE_OFFSET) >= CHAR_LOWER_LO && (c | CASE_OFFSET) <= CHAR_LOWER_HI &&
                $urandom_range(0, 3) == 0) begin
                c = c ^ CASE_OFFSET;
            end
            q.push_back(c);
        end
        return q;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("Result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
            end
        end
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready = 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            out_if.ready = 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            out_if.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("Result %0d arrived with no search pending", results_seen);
                end
            end else begin
                want = expected_q.pop_front();
                check_field("found", want.found, out_if.found);
                check_field("match_start", want.match_start, out_if.match_start);
                check_field("match_end", want.match_end, out_if.match_end);
                check_field("line_overflow", want.line_overflow, out_if.line_overflow);
            end
        end
    end

    task automatic send_req(input t_request r);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.command = r.command;
        in_if.pattern_slot = r.slot;
        in_if.pattern_position = r.position;
        in_if.pattern_length = r.length;
        in_if.data_byte = r.data;
        in_if.last_byte = r.last;
        in_if.search_from = r.from;
        in_if.valid = 1'b1;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        apply_request(r);
        requests_sent++;
    endtask

    task automatic put_byte(input int slot, input int pos, input logic [BYTE_W-1:0] b);
        t_request r;
        r = filler(CMD_PAT_BYTE);
        r.slot = SLOT_W'(slot);
        r.position = POS_W'(pos);
        r.data = b;
        send_req(r);
    endtask

    task automatic put_length(input int slot, input int len);
        t_request r;
        r = filler(CMD_PAT_LEN);
        r.slot = SLOT_W'(slot);
        r.length = PLEN_W'(len);
        send_req(r);
    endtask

    task automatic load_pattern(input int slot, input t_bytes chars);
        foreach (chars[i]) begin
            put_byte(slot, i, chars[i]);
        end
        put_length(slot, chars.size());
    endtask

    task automatic send_line(input t_bytes chars, input int from);
        t_request r;
        foreach (chars[i]) begin
            r = filler(CMD_LINE_BYTE);
            r.data = chars[i];
            r.last = (i == chars.size() - 1);
            if (r.last) begin
                r.from = OFS_W'(from);
            end
            send_req(r);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_if.index = idx;
        cfg_if.data = value;
        cfg_if.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_config(idx, value);
        cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic test_register_writes();
        write_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)), '1);
        write_reg(CFG_IGNORE_CASE, '0);
        write_reg(CFG_WORD_MATCH, '0);
        write_reg(CFG_LINE_MATCH, '0);
        write_reg(CFG_PATTERN_COUNT, CFG_DATA_W'(2));
        send_line(text_bytes("q"), 0);
    endtask

    task automatic test_basic_search();
        t_request r;
        load_pattern(0, '{8'hFF, 8'h00});
        load_pattern(1, text_bytes("x"));
        send_line('{8'h00, 8'hFF, 8'h00}, 0);
        send_line(text_bytes("x"), 0);
        send_line(text_bytes("axb x"), 2);
        send_line(text_bytes("xy"), 5);
        r = filler(CMD_UNUSED);
        r.last = 1'b1;
        send_req(r);
        r = filler(CMD_PAT_BYTE);
        r.slot = SLOT_W'(NUM_SLOTS - 1);
        r.position = POS_W'(SLOT_BYTES - 1);
        r.data = '1;
        r.last = 1'b1;
        send_req(r);
        r = filler(CMD_PAT_LEN);
        r.slot = SLOT_W'(2);
        r.length = '0;
        r.last = 1'b1;
        r.from = '1;
        send_req(r);
        settle();
        write_reg(CFG_PATTERN_COUNT, '1);
        send_line(text_bytes("zz"), 1);
        send_line(text_bytes("zz"), (1 << OFS_W) - 1);
    endtask

    task automatic test_case_and_word();
        settle();
        write_reg(CFG_PATTERN_COUNT, CFG_DATA_W'(2));
        write_reg(CFG_IGNORE_CASE, CFG_DATA_W'(1));
        write_reg(CFG_WORD_MATCH, CFG_DATA_W'(1));
        load_pattern(0, text_bytes("Ab_"));
        load_pattern(1, text_bytes("c9"));
        send_line(text_bytes("xab_ aB_"), 0);
        send_line(text_bytes("-C9-"), 0);
        settle();
        write_reg(CFG_IGNORE_CASE, '0);
        send_line(text_bytes("aB_ Ab_"), 0);
    endtask

    task automatic test_whole_line();
        settle();
        write_reg(CFG_LINE_MATCH, CFG_DATA_W'(1));
        send_line(text_bytes("c9"), 7);
        send_line(text_bytes("c9 "), 0);
    endtask

    task automatic test_long_pattern();
        t_bytes chars;
        settle();
        write_reg(CFG_PATTERN_COUNT, CFG_DATA_W'(NUM_SLOTS));
        write_reg(CFG_WORD_MATCH, '0);
        for (int i = 0; i < SLOT_BYTES; i++) begin
            chars.push_back(BYTE_W'($urandom));
            put_byte(NUM_SLOTS - 1, i, chars[i]);
        end
        put_length(NUM_SLOTS - 1, (1 << PLEN_W) - 1);
        send_line(chars, 0);
        chars.push_back(UNDERSCORE);
        send_line(chars, 0);
    endtask

    task automatic test_line_overflow();
        t_bytes chars;
        settle();
        write_reg(CFG_LINE_MATCH, '0);
        write_reg(CFG_PATTERN_COUNT, CFG_DATA_W'(2));
        for (int i = 0; i < LINE_CAP + 2; i++) begin
            chars.push_back("q");
        end
        chars[700] = "c";
        chars[701] = "9";
        chars[LINE_CAP] = "c";
        chars[LINE_CAP + 1] = "9";
        send_line(chars, 0);
        send_line(text_bytes("c9"), 0);
    endtask

    task automatic test_random_traffic();
        int                    first;
        int                    cnt;
        int                    slot;
        int                    len;
        int                    pos;
        int                    from;
        logic [CFG_DATA_W-1:0] v;
        t_bytes                chars;
        t_bytes                pat;
        t_request              r;
        settle();
        for (int s = 0; s < NUM_SLOTS; s++) begin
            load_pattern(s, random_chars($urandom_range(1, 4)));
        end
        first = requests_sent;
        while (requests_sent - first < RANDOM_ITEMS) begin
            if (requests_sent - first > RANDOM_ITEMS * 5 / 6) begin
                idle_on = 1'b0;
            end
            settle();
            if ($urandom_range(0, 5) == 0) begin
                write_reg(CFG_PATTERN_COUNT, CFG_DATA_W'($urandom));
            end else begin
                write_reg(CFG_PATTERN_COUNT, CFG_DATA_W'($urandom_range(1, NUM_SLOTS)));
            end
            write_reg(CFG_IGNORE_CASE, CFG_DATA_W'($urandom));
            write_reg(CFG_WORD_MATCH, CFG_DATA_W'($urandom));
            v = CFG_DATA_W'($urandom);
            v[0] = ($urandom_range(0, 2) == 0);
            write_reg(CFG_LINE_MATCH, v);
            repeat ($urandom_range(1, 3)) begin
                slot = $urandom_range(0, NUM_SLOTS - 1);
                case ($urandom_range(0, 15))
                    0:       len = 0;
                    1:       len = $urandom_range(7, SLOT_BYTES);
                    default: len = $urandom_range(1, 6);
                endcase
                load_pattern(slot, random_chars(len));
            end
            case ($urandom_range(0, 5))
                0: begin
                    r = filler(CMD_PAT_BYTE);
                    send_req(r);
                end
                1: begin
                    slot = $urandom_range(0, NUM_SLOTS - 1);
                    len = written_prefix(slot);
                    if (len == SLOT_BYTES) begin
                        put_length(slot, $urandom_range(0, (1 << PLEN_W) - 1));
                    end else begin
                        put_length(slot, $urandom_range(0, len));
                    end
                end
                2: begin
                    r = filler(CMD_UNUSED);
                    send_req(r);
                end
                default: begin
                end
            endcase
            repeat ($urandom_range(3, 8)) begin
                chars = random_chars($urandom_range(1, 24));
                cnt = (cfg_count > NUM_SLOTS) ? NUM_SLOTS : cfg_count;
                if (cnt > 0 && $urandom_range(0, 2) != 0) begin
                    slot = $urandom_range(0, cnt - 1);
                    pat = stored_variant(slot);
                    if (pat.size() > 0) begin
                        if (cfg_whole && $urandom_range(0, 1) == 0) begin
                            chars = pat;
                        end else begin
                            pos = $urandom_range(0, chars.size());
                            for (int k = pat.size() - 1; k >= 0; k--) begin
                                chars.insert(pos, pat[k]);
                            end
                        end
                    end
                end
                case ($urandom_range(0, 7))
                    5, 6:    from = $urandom_range(0, chars.size());
                    7:       from = $urandom_range(0, (1 << OFS_W) - 1);
                    default: from = 0;
                endcase
                send_line(chars, from);
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.command = CMD_PAT_BYTE;
        in_if.pattern_slot = '0;
        in_if.pattern_position = '0;
        in_if.pattern_length = '0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        in_if.search_from = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_PATTERN_COUNT;
        cfg_if.data = '0;
        idle_on = 1'b1;
        foreach (pat_len[s]) begin
            pat_len[s] = 0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_register_writes();
        test_basic_search();
        test_case_and_word();
        test_whole_line();
        test_long_pattern();
        test_line_overflow();
        test_random_traffic();
        settle();
        errors += expected_q.size();

        $display("Sent %0d requests and %0d register writes; checked %0d search results.",
                 requests_sent, cfg_writes, results_seen);
        $display("Covered case folding, word and line modes, odd lengths, %0d overflowing lines.",
                 overflow_lines);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/fslm_pkg.sv
hdl/fslm_in_if.sv
hdl/fslm_out_if.sv
hdl/fslm_cfg_if.sv
hdl/fslm_ctrl.sv
hdl/fslm_dpath.sv
hdl/fixed_string_line_matcher.sv
dv/tb_fixed_string_line_matcher.sv
